>>> src/rcfr_pkg.sv
// shared types, constants and the crc-8 step for the rc channel frame receiver
// no dependencies
package rcfr_pkg;

   localparam int CHANNEL_COUNT = 16;
   localparam int CH_IDX_W      = 4;
   localparam int CH_VALUE_W    = 11;
   localparam int PAYLOAD_BYTES = 22;
   localparam int PAYLOAD_W     = PAYLOAD_BYTES * 8;
   localparam int PAY_IDX_W     = 5;
   localparam int MIN_CH_LENGTH = 24;
   localparam int RSP_DATA_W    = 48;
   localparam int RSP_USER_W    = 16;

   localparam logic [7:0] SYNC_RESET     = 8'hC8;
   localparam logic [7:0] CH_TYPE_RESET  = 8'h16;
   localparam logic [7:0] CRC_POLY       = 8'hD5;
   localparam logic [7:0] LEN_ABORT      = 8'hFF;

   typedef enum logic [1:0] {
      PH_HUNT = 2'd0,
      PH_LEN  = 2'd1,
      PH_BODY = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_INVALID = 2'd1,
      ST_SHORT   = 2'd2,
      ST_OTHER   = 2'd3
   } status_type;

   typedef enum logic {
      CSR_SYNC    = 1'b0,
      CSR_CH_TYPE = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [PAYLOAD_W-1:0] payload;
      logic                 multi;
      logic [31:0]          frame_number;
      logic [7:0]           type_code;
      status_type           status;
   } entry_type;

   function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int k = 0; k < 8; k++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

>>> src/rcfr_front.sv
// byte parser: sync hunt, length, crc and payload capture, frame classification
// depends on rcfr_pkg
module rcfr_front
   import rcfr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          byte_valid,
   input  logic [7:0]    rx_byte,
   input  logic          space_ok,
   input  logic          csr_we,
   input  csr_index_type csr_index,
   input  logic [7:0]    csr_wdata,
   output logic          push,
   output entry_type     push_entry
);

   phase_type   phase_ff, phase_in;
   logic [7:0]  rem_ff, rem_in;
   logic [7:0]  decl_ff, decl_in;
   logic [7:0]  crc_ff, crc_in;
   logic [7:0]  type_ff, type_in;
   logic [31:0] count_ff, count_in;
   logic [7:0]  sync_ff, sync_in;
   logic [7:0]  ch_type_ff, ch_type_in;
   logic [7:0]  payload_ff [PAYLOAD_BYTES];

   logic                 accept;
   logic [7:0]           pos;
   logic [7:0]           pos_m1;
   logic                 pay_we;
   logic [7:0]           type_cur;
   logic [PAYLOAD_W-1:0] payload_flat;

   assign accept = byte_valid && space_ok;
   assign pos    = decl_ff - rem_ff;
   assign pos_m1 = pos - 8'd1;

   always_comb begin
      for (int k = 0; k < PAYLOAD_BYTES; k++) begin
         payload_flat[k*8 +: 8] = payload_ff[k];
      end
   end

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         case (phase_ff)
            PH_HUNT: phase_in = (rx_byte == sync_ff) ? PH_LEN : PH_HUNT;
            PH_LEN:  phase_in = (rx_byte == 8'd0 || rx_byte == LEN_ABORT) ? PH_HUNT : PH_BODY;
            PH_BODY: phase_in = (rem_ff <= 8'd1) ? PH_HUNT : PH_BODY;
            default: phase_in = PH_HUNT;
         endcase
      end
   end

   // datapath and frame end
   always_comb begin
      rem_in                  = rem_ff;
      decl_in                 = decl_ff;
      crc_in                  = crc_ff;
      type_in                 = type_ff;
      count_in                = count_ff;
      pay_we                  = 1'b0;
      push                    = 1'b0;
      type_cur                = (pos == 8'd0) ? rx_byte : type_ff;
      push_entry.payload      = payload_flat;
      push_entry.multi        = 1'b0;
      push_entry.frame_number = count_ff + 32'd1;
      push_entry.type_code    = 8'd0;
      push_entry.status       = ST_INVALID;
      if (accept) begin
         case (phase_ff)
            PH_LEN: begin
               decl_in = rx_byte;
               rem_in  = rx_byte;
               crc_in  = 8'd0;
               type_in = 8'd0;
               if (rx_byte == 8'd0 || rx_byte == LEN_ABORT) begin
                  push = 1'b1;
               end
            end
            PH_BODY: begin
               if (rem_ff != 8'd0) begin
                  rem_in = rem_ff - 8'd1;
                  if (pos == 8'd0) begin
                     type_in = rx_byte;
                  end
                  if (rem_ff != 8'd1) begin
                     crc_in = crc_step(crc_ff, rx_byte);
                     pay_we = (pos >= 8'd1) && (pos <= 8'(PAYLOAD_BYTES));
                  end else begin
                     push                 = 1'b1;
                     push_entry.type_code = type_cur;
                     if (decl_ff < 8'd2 || rx_byte != crc_ff) begin
                        push_entry.status = ST_INVALID;
                     end else if (type_cur != ch_type_ff) begin
                        push_entry.status = ST_OTHER;
                     end else if (decl_ff < 8'(MIN_CH_LENGTH)) begin
                        push_entry.status = ST_SHORT;
                     end else begin
                        push_entry.status = ST_OK;
                        push_entry.multi  = 1'b1;
                     end
                  end
               end
            end
            default: begin
            end
         endcase
      end
      if (push) begin
         count_in = count_ff + 32'd1;
      end
   end

   always_comb begin
      sync_in    = sync_ff;
      ch_type_in = ch_type_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_SYNC:    sync_in    = csr_wdata;
            CSR_CH_TYPE: ch_type_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HUNT;
         rem_ff     <= 8'd0;
         decl_ff    <= 8'd0;
         crc_ff     <= 8'd0;
         type_ff    <= 8'd0;
         count_ff   <= 32'd0;
         sync_ff    <= SYNC_RESET;
         ch_type_ff <= CH_TYPE_RESET;
      end else begin
         phase_ff   <= phase_in;
         rem_ff     <= rem_in;
         decl_ff    <= decl_in;
         crc_ff     <= crc_in;
         type_ff    <= type_in;
         count_ff   <= count_in;
         sync_ff    <= sync_in;
         ch_type_ff <= ch_type_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pay_we) begin
         payload_ff[pos_m1[PAY_IDX_W-1:0]] <= rx_byte;
      end
   end

endmodule

>>> src/rcfr_queue.sv
// two-entry queue of finished frame descriptors between parser and emitter
// depends on rcfr_pkg
module rcfr_queue
   import rcfr_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      wr_en,
   input  entry_type wr_data,
   input  logic      rd_en,
   output entry_type rd_data,
   output logic      full,
   output logic      empty
);

   entry_type  slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_wr;
   logic       do_rd;

   assign full    = (count_ff == 2'd2);
   assign empty   = (count_ff == 2'd0);
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_wr ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_rd ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_wr} - {1'b0, do_rd};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

>>> src/rcfr_back.sv
// result emitter: one status result or an 11-bit channel unpack per output transaction
// depends on rcfr_pkg
module rcfr_back
   import rcfr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_empty,
   input  entry_type             q_data,
   output logic                  pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [RSP_USER_W-1:0] rsp_tuser,
   output logic                  rsp_tlast
);

   logic                 valid_ff, valid_in;
   logic                 multi_ff, multi_in;
   status_type           status_ff, status_in;
   logic [7:0]           type_ff, type_in;
   logic [31:0]          number_ff, number_in;
   logic [CH_IDX_W-1:0]  idx_ff, idx_in;
   logic [PAYLOAD_W-1:0] shift_ff, shift_in;

   logic                  out_acc;
   logic                  is_last;
   logic [CH_IDX_W-1:0]   idx_out;
   logic [CH_VALUE_W-1:0] value_out;

   assign out_acc   = valid_ff && rsp_tready;
   assign is_last   = !multi_ff || (idx_ff == CH_IDX_W'(CHANNEL_COUNT - 1));
   assign pop       = !q_empty && (!valid_ff || (out_acc && is_last));
   assign idx_out   = multi_ff ? idx_ff : '0;
   assign value_out = multi_ff ? shift_ff[CH_VALUE_W-1:0] : '0;

   assign rsp_tvalid = valid_ff;
   assign rsp_tlast  = is_last;
   assign rsp_tdata  = {1'b0, value_out, idx_out, number_ff};
   assign rsp_tuser  = {6'd0, type_ff, status_ff};

   always_comb begin
      valid_in  = valid_ff;
      multi_in  = multi_ff;
      status_in = status_ff;
      type_in   = type_ff;
      number_in = number_ff;
      idx_in    = idx_ff;
      shift_in  = shift_ff;
      if (pop) begin
         valid_in  = 1'b1;
         multi_in  = q_data.multi;
         status_in = q_data.status;
         type_in   = q_data.type_code;
         number_in = q_data.frame_number;
         idx_in    = '0;
         shift_in  = q_data.payload;
      end else if (out_acc) begin
         if (is_last) begin
            valid_in = 1'b0;
         end else begin
            idx_in   = idx_ff + CH_IDX_W'(1);
            shift_in = shift_ff >> CH_VALUE_W;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      multi_ff  <= multi_in;
      status_ff <= status_in;
      type_ff   <= type_in;
      number_ff <= number_in;
      idx_ff    <= idx_in;
      shift_ff  <= shift_in;
   end

endmodule

>>> src/rc_channel_frame_receiver.sv
// rc channel frame receiver: parser front, two-entry descriptor queue, result emitter
// one received byte per cycle while the queue has room; a finished frame is written to the
// queue, then loaded into the emitter registers once they are free, then one result per cycle as taken:
// one for a status-only frame, sixteen for a valid channels frame
// synchronous active-high reset: hunting for sync, counters zero, sync 0xC8, type 0x16
// depends on rcfr_pkg, rcfr_front, rcfr_queue, rcfr_back
module rc_channel_frame_receiver
   import rcfr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // rx_byte
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // frame_number, channel_index, channel_value
   output logic [RSP_USER_W-1:0] rsp_tuser,   // status, type code
   output logic                  rsp_tlast,
   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [7:0]            csr_wdata
);

   logic      q_full;
   logic      q_empty;
   logic      push;
   logic      pop;
   entry_type push_entry;
   entry_type q_data;

   assign req_tready = !q_full;

   rcfr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (req_tvalid),
      .rx_byte    (req_tdata),
      .space_ok   (!q_full),
      .csr_we     (csr_we),
      .csr_index  (csr_index_type'(csr_index)),
      .csr_wdata  (csr_wdata),
      .push       (push),
      .push_entry (push_entry)
   );

   rcfr_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (push),
      .wr_data (push_entry),
      .rd_en   (pop),
      .rd_data (q_data),
      .full    (q_full),
      .empty   (q_empty)
   );

   rcfr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_data     (q_data),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

>>> tb/tb_rc_channel_frame_receiver.sv
// self-checking testbench for rc_channel_frame_receiver: byte stream in, frame reports out
// a local parser predicts each report; directed frames first, then random ones under
// four sync/type settings; depends on rcfr_pkg and the rc_channel_frame_receiver rtl
`timescale 1ns / 100ps

module tb_rc_channel_frame_receiver
   import rcfr_pkg::*;
();

   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_WAIT  = 20;
   localparam int HOLD_CYCLES = 300;

   typedef struct packed {
      status_type  status;
      logic [7:0]  type_code;
      logic [31:0] frame_number;
      logic [3:0]  ch_index;
      logic [10:0] ch_value;
      logic        ch_last;
   } frame_report_type;

   typedef enum {RAW_BYTE, GOOD_CRC, BAD_CRC} row_kind_type;

   typedef struct {
      row_kind_type kind;
      logic [7:0]   value;
      bit           typed;
      status_type   status;
      logic [7:0]   type_code;
      logic [31:0]  frame_number;
   } rx_row_type;

   typedef enum {FK_CH_OK, FK_CH_SHORT, FK_OTHER, FK_BAD_CRC, FK_ODD_LEN, FK_NOISE}
      frame_kind_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [7:0]            req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_we;
   logic                  csr_index;
   logic [7:0]            csr_wdata;

   // parser mirror
   phase_type            rx_phase;
   logic [7:0]           bytes_left;
   logic [7:0]           decl_len;
   logic [7:0]           crc_run;
   logic [7:0]           type_seen;
   logic [PAYLOAD_W-1:0] payload_bits;
   logic [31:0]          frames_done;
   logic [7:0]           cfg_sync;
   logic [7:0]           cfg_ch_type;
   frame_report_type     burst [CHANNEL_COUNT];

   frame_report_type frame_reports_due [$];
   frame_report_type seen_rep;
   frame_report_type due_rep;
   int               status_count [4];
   int               items_sent;
   int               results_checked;
   int               errors;
   int               cycles;
   bit               calm;
   bit               hold_req;

   rx_row_type directed_rows [22] = '{
      '{RAW_BYTE, 8'h00,          1'b0, ST_OK,      8'h00,         32'd0},
      '{RAW_BYTE, 8'hFF,          1'b0, ST_OK,      8'h00,         32'd0},
      '{RAW_BYTE, SYNC_RESET,     1'b0, ST_OK,      8'h00,         32'd0},
      '{RAW_BYTE, 8'h00,          1'b1, ST_INVALID, 8'h00,         32'd1},
      '{RAW_BYTE, SYNC_RESET,     1'b0, ST_OK,      8'h00,         32'd0},
      '{RAW_BYTE, LEN_ABORT,      1'b1, ST_INVALID, 8'h00,         32'd2},
      '{RAW_BYTE, SYNC_RESET,     1'b0, ST_OK,      8'h00,         32'd0},
      '{RAW_BYTE, 8'h01,          1'b0, ST_OK,      8'h00,         32'd0},
      '{RAW_BYTE, 8'h5A,          1'b1, ST_INVALID, 8'h5A,         32'd3},
      '{RAW_BYTE, SYNC_RESET,     1'b0, ST_OK,      8'h00,         32'd0},
      '{RAW_BYTE, 8'h02,          1'b0, ST_OK,      8'h00,         32'd0},
      '{RAW_BYTE, CH_TYPE_RESET,  1'b0, ST_OK,      8'h00,         32'd0},
      '{BAD_CRC,  8'h00,          1'b1, ST_INVALID, CH_TYPE_RESET, 32'd4},
      '{RAW_BYTE, SYNC_RESET,     1'b0, ST_OK,      8'h00,         32'd0},
      '{RAW_BYTE, 8'h02,          1'b0, ST_OK,      8'h00,         32'd0},
      '{RAW_BYTE, CH_TYPE_RESET,  1'b0, ST_OK,      8'h00,         32'd0},
      '{GOOD_CRC, 8'h00,          1'b1, ST_SHORT,   CH_TYPE_RESET, 32'd5},
      '{RAW_BYTE, SYNC_RESET,     1'b0, ST_OK,      8'h00,         32'd0},
      '{RAW_BYTE, 8'h03,          1'b0, ST_OK,      8'h00,         32'd0},
      '{RAW_BYTE, 8'h2A,          1'b0, ST_OK,      8'h00,         32'd0},
      '{RAW_BYTE, 8'h55,          1'b0, ST_OK,      8'h00,         32'd0},
      '{GOOD_CRC, 8'h00,          1'b1, ST_OTHER,   8'h2A,         32'd6}
   };

   rc_channel_frame_receiver uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),    // rx_byte
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),    // frame_number, channel_index, channel_value
      .rsp_tuser  (rsp_tuser),    // status, type code
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // crc-8, polynomial 0xd5, msb first
   function automatic logic [7:0] crc8_d5(input logic [7:0] acc, input logic [7:0] b);
      logic [7:0] r;
      r = acc ^ b;
      repeat (8) r = r[7] ? ((r << 1) ^ 8'hD5) : (r << 1);
      return r;
   endfunction

   function automatic int close_frame(input status_type st, input logic [7:0] tp);
      frames_done = frames_done + 1;
      rx_phase = PH_HUNT;
      status_count[st]++;
      burst[0] = '{st, tp, frames_done, 4'd0, 11'd0, 1'b1};
      return 1;
   endfunction

   // advances the parser mirror by one byte, leaves the reports in burst
   function automatic int parse_rx_byte(input logic [7:0] b);
      int pos;
      int n;
      n = 0;
      case (rx_phase)
         PH_LEN: begin
            decl_len = b;
            bytes_left = b;
            crc_run = 8'h00;
            type_seen = 8'h00;
            if (b == 8'h00 || b == LEN_ABORT) begin
               n = close_frame(ST_INVALID, 8'h00);
            end else begin
               rx_phase = PH_BODY;
            end
         end
         PH_BODY: begin
            if (bytes_left == 8'h00) begin
               rx_phase = PH_HUNT;
            end else begin
               pos = int'(decl_len) - int'(bytes_left);
               bytes_left = bytes_left - 8'd1;
               if (pos == 0) type_seen = b;
               if (bytes_left != 8'h00) begin
                  crc_run = crc8_d5(crc_run, b);
                  if (pos >= 1 && pos <= PAYLOAD_BYTES) payload_bits[(pos-1)*8 +: 8] = b;
               end else if (decl_len < 8'd2 || b != crc_run) begin
                  n = close_frame(ST_INVALID, type_seen);
               end else if (type_seen != cfg_ch_type) begin
                  n = close_frame(ST_OTHER, type_seen);
               end else if (decl_len < MIN_CH_LENGTH) begin
                  n = close_frame(ST_SHORT, type_seen);
               end else begin
                  frames_done = frames_done + 1;
                  rx_phase = PH_HUNT;
                  status_count[ST_OK]++;
                  for (int i = 0; i < CHANNEL_COUNT; i++) begin
                     burst[i] = '{ST_OK, type_seen, frames_done, 4'(i),
                                  payload_bits[i*CH_VALUE_W +: CH_VALUE_W],
                                  (i == CHANNEL_COUNT - 1)};
                  end
                  n = CHANNEL_COUNT;
               end
            end
         end
         default: rx_phase = (b == cfg_sync) ? PH_LEN : PH_HUNT;
      endcase
      return n;
   endfunction

   task automatic send_byte(input logic [7:0] b, input bit counted, input bit typed,
                            input frame_report_type typed_rep);
      int n;
      if (!calm && $urandom_range(0, 99) < 20) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < 30);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (req_tready !== 1'b1);
      n = parse_rx_byte(b);
      if (typed) begin
         frame_reports_due.push_back(typed_rep);
      end else begin
         for (int k = 0; k < n; k++) frame_reports_due.push_back(burst[k]);
      end
      if (counted) items_sent++;
   endtask

   task automatic send_frame(input frame_kind_type kind);
      logic [7:0] len;
      logic [7:0] tp;
      logic [7:0] crc;
      logic [7:0] pl;
      logic [7:0] noise;
      case (kind)
         FK_CH_OK: begin
            len = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(25, 60))
                                               : 8'($urandom_range(24, 26));
            tp = cfg_ch_type;
         end
         FK_CH_SHORT: begin
            len = 8'($urandom_range(2, 23));
            tp = cfg_ch_type;
         end
         FK_OTHER: begin
            len = 8'($urandom_range(2, 40));
            do tp = 8'($urandom_range(0, 255)); while (tp == cfg_ch_type);
         end
         FK_BAD_CRC: begin
            len = 8'($urandom_range(2, 30));
            tp = 8'($urandom_range(0, 255));
         end
         FK_ODD_LEN: begin
            case ($urandom_range(0, 2))
               0: len = 8'h00;
               1: len = 8'h01;
               default: len = LEN_ABORT;
            endcase
            tp = 8'($urandom_range(0, 255));
         end
         default: begin
            len = 8'h00;
            tp = 8'h00;
         end
      endcase
      if (kind == FK_NOISE) begin
         repeat ($urandom_range(1, 3)) begin
            do noise = 8'($urandom_range(0, 255)); while (noise == cfg_sync);
            send_byte(noise, 1'b1, 1'b0, '0);
         end
      end else begin
         send_byte(cfg_sync, 1'b1, 1'b0, '0);
         send_byte(len, 1'b1, 1'b0, '0);
         if (len == 8'h01) begin
            send_byte(tp, 1'b1, 1'b0, '0);
         end else if (len != 8'h00 && len != LEN_ABORT) begin
            send_byte(tp, 1'b1, 1'b0, '0);
            crc = crc8_d5(8'h00, tp);
            for (int k = 0; k < int'(len) - 2; k++) begin
               pl = 8'($urandom_range(0, 255));
               crc = crc8_d5(crc, pl);
               send_byte(pl, 1'b1, 1'b0, '0);
            end
            if (kind == FK_BAD_CRC) crc = crc ^ 8'($urandom_range(1, 255));
            send_byte(crc, 1'b1, 1'b0, '0);
         end
      end
   endtask

   task automatic run_random(input int target);
      int r;
      while (items_sent < target) begin
         r = $urandom_range(0, 99);
         if (r < 40)      send_frame(FK_CH_OK);
         else if (r < 55) send_frame(FK_CH_SHORT);
         else if (r < 68) send_frame(FK_OTHER);
         else if (r < 80) send_frame(FK_BAD_CRC);
         else if (r < 90) send_frame(FK_ODD_LEN);
         else             send_frame(FK_NOISE);
      end
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (frame_reports_due.size() != 0) @(posedge clock);
   endtask

   task automatic set_regs(input logic [7:0] sync_byte, input logic [7:0] ch_type);
      wait_drained();
      repeat (8) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_SYNC;
      csr_wdata <= sync_byte;
      @(posedge clock);
      csr_index <= CSR_CH_TYPE;
      csr_wdata <= ch_type;
      @(posedge clock);
      csr_we <= 1'b0;
      cfg_sync = sync_byte;
      cfg_ch_type = ch_type;
   endtask

   task automatic check_field(input string what, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         errors++;
         if (errors <= 40)
            $display("%0t %s mismatch: expected %0h actual %0h", $time, what, want, got);
      end
   endtask

   // result monitor
   always @(posedge clock) begin
      if (rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         seen_rep = '{status_type'(rsp_tuser[1:0]), rsp_tuser[9:2], rsp_tdata[31:0],
                      rsp_tdata[35:32], rsp_tdata[46:36], rsp_tlast};
         results_checked++;
         if (frame_reports_due.size() == 0) begin
            errors++;
            if (errors <= 40)
               $display("%0t unexpected transaction: expected none actual %h",
                        $time, seen_rep);
         end else begin
            due_rep = frame_reports_due.pop_front();
            check_field("status", 32'(due_rep.status), 32'(seen_rep.status));
            check_field("type code", 32'(due_rep.type_code), 32'(seen_rep.type_code));
            check_field("frame_number", due_rep.frame_number, seen_rep.frame_number);
            check_field("channel_index", 32'(due_rep.ch_index), 32'(seen_rep.ch_index));
            check_field("channel_value", 32'(due_rep.ch_value), 32'(seen_rep.ch_value));
            check_field("last", 32'(due_rep.ch_last), 32'(seen_rep.ch_last));
         end
      end
   end

   // result side backpressure, with one long hold-off on request
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_req) begin
            hold_req = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_tready <= calm || ($urandom_range(0, 99) >= 20);
      end
   end

   initial begin
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("timeout after %0d cycles", cycles);
      $display("FAILED: results differ");
      $finish;
   end

   initial begin
      logic [7:0] b;
      frame_report_type rep;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = 8'h00;
      csr_we = 1'b0;
      csr_index = CSR_SYNC;
      csr_wdata = 8'h00;
      calm = 1'b0;
      hold_req = 1'b0;
      items_sent = 0;
      results_checked = 0;
      errors = 0;
      rx_phase = PH_HUNT;
      bytes_left = 8'h00;
      decl_len = 8'h00;
      crc_run = 8'h00;
      type_seen = 8'h00;
      payload_bits = '0;
      frames_done = 32'd0;
      cfg_sync = SYNC_RESET;
      cfg_ch_type = CH_TYPE_RESET;
      for (int s = 0; s < 4; s++) status_count[s] = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         case (directed_rows[r].kind)
            GOOD_CRC: b = crc_run;
            BAD_CRC:  b = crc_run ^ 8'h01;
            default:  b = directed_rows[r].value;
         endcase
         rep = '{directed_rows[r].status, directed_rows[r].type_code,
                 directed_rows[r].frame_number, 4'd0, 11'd0, 1'b1};
         send_byte(b, 1'b1, directed_rows[r].typed, rep);
      end

      // reset settings, long result stall at the start
      hold_req = 1'b1;
      run_random(105);
      // extreme settings, first one with no idling at all
      calm = 1'b1;
      set_regs(8'h00, 8'hFF);
      run_random(155);
      calm = 1'b0;
      set_regs(8'hFF, 8'h00);
      run_random(205);
      set_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      run_random(255);

      wait_drained();
      repeat (DRAIN_WAIT) @(posedge clock);
      $display("covered %0d rx bytes in %0d frames: %0d channel sets, %0d invalid, %0d short,",
               items_sent, frames_done, status_count[ST_OK], status_count[ST_INVALID],
               status_count[ST_SHORT]);
      $display("%0d other type; %0d results checked over four sync/type settings",
               status_count[ST_OTHER], results_checked);
      if (errors == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
